// ----- rtl/assert_macros.svh -----
// assertion macros for the scheduler rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TLPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TLPQ_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define TLPQ_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/tlpq_pkg.sv -----
// shared types and constants of the two-level queue scheduler
// no dependencies; used by the interfaces and the top level
package tlpq_pkg;

  localparam int SLOT_FIELD_W  = 5;
  localparam int BURST_FIELD_W = 16;
  localparam int TIME_W        = 32;
  localparam int STATUS_W      = 2;

  localparam logic CLS_SYSTEM = 1'b1;
  localparam logic CLS_USER   = 1'b0;

  typedef enum logic {
    CMD_ARRIVE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_ACCEPTED = 2'd0,
    STATUS_REJECTED = 2'd1,
    STATUS_RAN      = 2'd2,
    STATUS_IDLE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_CHECK,
    ST_PICK,
    ST_FETCH,
    ST_RUN,
    ST_OUT
  } state_t;

endpackage

// ----- rtl/tlpq_in_if.sv -----
// input channel of the scheduler: valid/ready plus one command item
// depends on tlpq_pkg for field widths
interface tlpq_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic [tlpq_pkg::SLOT_FIELD_W-1:0]   task_slot;
  logic [tlpq_pkg::BURST_FIELD_W-1:0]  burst_len;
  logic                                is_system;

  modport source (output valid, output cmd, output task_slot, output burst_len,
                  output is_system, input ready);
  modport sink (input valid, input cmd, input task_slot, input burst_len,
                input is_system, output ready);
endinterface

// ----- rtl/tlpq_out_if.sv -----
// result channel of the scheduler: valid/ready plus one result item
// depends on tlpq_pkg for field widths
interface tlpq_out_if;
  logic                               valid;
  logic                               ready;
  logic [tlpq_pkg::STATUS_W-1:0]      status;
  logic [tlpq_pkg::SLOT_FIELD_W-1:0]  ran_slot;
  logic                               first_run;
  logic                               completed;
  logic [tlpq_pkg::TIME_W-1:0]        tick_time;

  modport source (output valid, output status, output ran_slot, output first_run,
                  output completed, output tick_time, input ready);
  modport sink (input valid, input status, input ran_slot, input first_run,
                input completed, input tick_time, output ready);
endinterface

// ----- rtl/tlpq_ram.sv -----
// generic single-clock ram, one write port and one registered read port
// no dependencies; holds the ready queues and the per-slot task records
module tlpq_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [2**ADDR_W];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/two_level_preemptive_queue_scheduler.sv -----
// channel  dir  handshake      payload
// in_ch    in   valid/ready    cmd, task_slot, burst_len, is_system
// out_ch   out  valid/ready    status, ran_slot, first_run, completed, tick_time
//
// arrival: idle, arrive, out; tick: idle, pick, out (idle); idle, check, run, out
// (running, no preemption); idle, pick, fetch, run, out (new pick); idle, check,
// pick, fetch, run, out (preempt then pick), set by the dependent registered reads of both rams
// reset: synchronous; busy and started flags are flip-flops, no clearing pass
// a result waits in the output register; the next item is taken meanwhile,
// a finished item stalls only its final load until out_ch is free
// depends on tlpq_pkg, tlpq_in_if, tlpq_out_if, tlpq_ram, assert_macros.svh
`include "assert_macros.svh"

module two_level_preemptive_queue_scheduler #(
  parameter int NUM_SLOTS  = 32,
  parameter int BURST_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  tlpq_in_if.sink    in_ch,
  tlpq_out_if.source out_ch
);

  localparam int SLOT_W  = $clog2(NUM_SLOTS);
  localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int SF_W    = tlpq_pkg::SLOT_FIELD_W;
  localparam int BF_W    = tlpq_pkg::BURST_FIELD_W;
  localparam int TM_W    = tlpq_pkg::TIME_W;
  localparam int EXT_W   = (SLOT_W > SF_W) ? SLOT_W : SF_W;
  localparam int BIN_W   = (BURST_BITS < BF_W) ? BURST_BITS : BF_W;
  localparam int TASK_W  = BURST_BITS + 1;
  localparam int FIFO_AW = SLOT_W + 1;

  tlpq_pkg::state_t state_r, state_nxt;

  // latched item
  logic [SF_W-1:0]  slot_r, slot_nxt;
  logic [BF_W-1:0]  burst_r, burst_nxt;
  logic             sys_r, sys_nxt;

  // scheduler control state
  logic [SLOT_W-1:0]    sys_head_r, sys_head_nxt, usr_head_r, usr_head_nxt;
  logic [CNT_W-1:0]     sys_cnt_r, sys_cnt_nxt, usr_cnt_r, usr_cnt_nxt;
  logic [SLOT_W-1:0]    run_slot_r, run_slot_nxt;
  logic                 run_valid_r, run_valid_nxt;
  logic [TM_W-1:0]      time_r, time_nxt;
  logic [NUM_SLOTS-1:0] busy_r, busy_nxt, started_r, started_nxt;

  // pending result and output register
  tlpq_pkg::status_t res_status_r, res_status_nxt;
  logic [SF_W-1:0]   res_slot_r, res_slot_nxt;
  logic              res_first_r, res_first_nxt;
  logic              res_done_r, res_done_nxt;
  logic [TM_W-1:0]   res_time_r, res_time_nxt;

  logic              out_valid_r, out_valid_nxt;
  tlpq_pkg::status_t out_status_r, out_status_nxt;
  logic [SF_W-1:0]   out_slot_r, out_slot_nxt;
  logic              out_first_r, out_first_nxt;
  logic              out_done_r, out_done_nxt;
  logic [TM_W-1:0]   out_time_r, out_time_nxt;

  // memory ports
  logic               task_we, task_re;
  logic [SLOT_W-1:0]  task_waddr, task_raddr;
  logic [TASK_W-1:0]  task_wdata, task_rd;
  logic               fifo_we, fifo_re;
  logic [FIFO_AW-1:0] fifo_waddr, fifo_raddr;
  logic [SLOT_W-1:0]  fifo_wdata, fifo_rd;

  // derived values
  logic                  in_accept, out_free;
  logic [SUM_W-1:0]      sys_sum, usr_sum;
  logic [SLOT_W-1:0]     sys_tail, usr_tail, sys_head_inc, usr_head_inc;
  logic [EXT_W-1:0]      slot_ext;
  logic                  in_range, arr_ok;
  logic [SLOT_W-1:0]     arr_idx;
  logic [BURST_BITS-1:0] burst_use, task_rem, new_rem;
  logic                  task_cls, preempt;

  tlpq_ram #(.WIDTH(TASK_W), .ADDR_W(SLOT_W)) u_task_ram (
    .clk     (clk),
    .wr_en   (task_we),
    .wr_addr (task_waddr),
    .wr_data (task_wdata),
    .rd_en   (task_re),
    .rd_addr (task_raddr),
    .rd_data (task_rd)
  );

  tlpq_ram #(.WIDTH(SLOT_W), .ADDR_W(FIFO_AW)) u_fifo_ram (
    .clk     (clk),
    .wr_en   (fifo_we),
    .wr_addr (fifo_waddr),
    .wr_data (fifo_wdata),
    .rd_en   (fifo_re),
    .rd_addr (fifo_raddr),
    .rd_data (fifo_rd)
  );

  assign in_accept = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;

  // ring tails and head increments
  assign sys_sum  = SUM_W'(sys_head_r) + SUM_W'(sys_cnt_r);
  assign usr_sum  = SUM_W'(usr_head_r) + SUM_W'(usr_cnt_r);
  assign sys_tail = (sys_sum >= SUM_W'(NUM_SLOTS)) ? SLOT_W'(sys_sum - SUM_W'(NUM_SLOTS))
                                                   : SLOT_W'(sys_sum);
  assign usr_tail = (usr_sum >= SUM_W'(NUM_SLOTS)) ? SLOT_W'(usr_sum - SUM_W'(NUM_SLOTS))
                                                   : SLOT_W'(usr_sum);
  assign sys_head_inc = (sys_head_r == SLOT_W'(NUM_SLOTS - 1)) ? '0 : sys_head_r + 1'b1;
  assign usr_head_inc = (usr_head_r == SLOT_W'(NUM_SLOTS - 1)) ? '0 : usr_head_r + 1'b1;

  // arrival checks
  assign slot_ext  = EXT_W'(slot_r);
  assign in_range  = ({1'b0, slot_ext} < (EXT_W + 1)'(NUM_SLOTS));
  assign arr_idx   = slot_ext[SLOT_W-1:0];
  assign burst_use = BURST_BITS'(burst_r[BIN_W-1:0]);
  assign arr_ok    = in_range && (burst_use != '0) && !busy_r[arr_idx];

  // task record fields
  assign task_cls = task_rd[BURST_BITS];
  assign task_rem = task_rd[BURST_BITS-1:0];
  assign new_rem  = (task_rem != '0) ? task_rem - 1'b1 : task_rem;
  assign preempt  = (task_cls == tlpq_pkg::CLS_USER) && (sys_cnt_r != '0);

  assign in_ch.ready      = (state_r == tlpq_pkg::ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.ran_slot  = out_slot_r;
  assign out_ch.first_run = out_first_r;
  assign out_ch.completed = out_done_r;
  assign out_ch.tick_time = out_time_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlpq_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_ch.cmd == tlpq_pkg::CMD_ARRIVE) begin
            state_nxt = tlpq_pkg::ST_ARRIVE;
          end else if (run_valid_r) begin
            state_nxt = tlpq_pkg::ST_CHECK;
          end else begin
            state_nxt = tlpq_pkg::ST_PICK;
          end
        end
      end
      tlpq_pkg::ST_ARRIVE: state_nxt = tlpq_pkg::ST_OUT;
      tlpq_pkg::ST_CHECK:  state_nxt = preempt ? tlpq_pkg::ST_PICK : tlpq_pkg::ST_RUN;
      tlpq_pkg::ST_PICK: begin
        state_nxt = ((sys_cnt_r != '0) || (usr_cnt_r != '0)) ? tlpq_pkg::ST_FETCH
                                                             : tlpq_pkg::ST_OUT;
      end
      tlpq_pkg::ST_FETCH:  state_nxt = tlpq_pkg::ST_RUN;
      tlpq_pkg::ST_RUN:    state_nxt = tlpq_pkg::ST_OUT;
      tlpq_pkg::ST_OUT:    state_nxt = out_free ? tlpq_pkg::ST_IDLE : tlpq_pkg::ST_OUT;
      default:             state_nxt = tlpq_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    slot_nxt       = slot_r;
    burst_nxt      = burst_r;
    sys_nxt        = sys_r;
    sys_head_nxt   = sys_head_r;
    usr_head_nxt   = usr_head_r;
    sys_cnt_nxt    = sys_cnt_r;
    usr_cnt_nxt    = usr_cnt_r;
    run_slot_nxt   = run_slot_r;
    run_valid_nxt  = run_valid_r;
    time_nxt       = time_r;
    busy_nxt       = busy_r;
    started_nxt    = started_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_first_nxt  = res_first_r;
    res_done_nxt   = res_done_r;
    res_time_nxt   = res_time_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_first_nxt  = out_first_r;
    out_done_nxt   = out_done_r;
    out_time_nxt   = out_time_r;
    task_we        = 1'b0;
    task_waddr     = '0;
    task_wdata     = '0;
    task_re        = 1'b0;
    task_raddr     = '0;
    fifo_we        = 1'b0;
    fifo_waddr     = '0;
    fifo_wdata     = '0;
    fifo_re        = 1'b0;
    fifo_raddr     = '0;

    unique case (state_r)
      tlpq_pkg::ST_IDLE: begin
        if (in_accept) begin
          slot_nxt  = in_ch.task_slot;
          burst_nxt = in_ch.burst_len;
          sys_nxt   = in_ch.is_system;
          // fetch the running task record for the preemption check
          if ((in_ch.cmd == tlpq_pkg::CMD_TICK) && run_valid_r) begin
            task_re    = 1'b1;
            task_raddr = run_slot_r;
          end
        end
      end
      tlpq_pkg::ST_ARRIVE: begin
        res_slot_nxt  = '0;
        res_first_nxt = 1'b0;
        res_done_nxt  = 1'b0;
        res_time_nxt  = time_r;
        if (arr_ok) begin
          res_status_nxt       = tlpq_pkg::STATUS_ACCEPTED;
          busy_nxt[arr_idx]    = 1'b1;
          started_nxt[arr_idx] = 1'b0;
          task_we              = 1'b1;
          task_waddr           = arr_idx;
          task_wdata           = {sys_r, burst_use};
          fifo_we              = 1'b1;
          fifo_wdata           = arr_idx;
          if (sys_r == tlpq_pkg::CLS_SYSTEM) begin
            fifo_waddr  = {tlpq_pkg::CLS_SYSTEM, sys_tail};
            sys_cnt_nxt = sys_cnt_r + 1'b1;
          end else begin
            fifo_waddr  = {tlpq_pkg::CLS_USER, usr_tail};
            usr_cnt_nxt = usr_cnt_r + 1'b1;
          end
        end else begin
          res_status_nxt = tlpq_pkg::STATUS_REJECTED;
        end
      end
      tlpq_pkg::ST_CHECK: begin
        if (preempt) begin
          fifo_we       = 1'b1;
          fifo_waddr    = {tlpq_pkg::CLS_USER, usr_tail};
          fifo_wdata    = run_slot_r;
          usr_cnt_nxt   = usr_cnt_r + 1'b1;
          run_valid_nxt = 1'b0;
        end
      end
      tlpq_pkg::ST_PICK: begin
        if (sys_cnt_r != '0) begin
          fifo_re      = 1'b1;
          fifo_raddr   = {tlpq_pkg::CLS_SYSTEM, sys_head_r};
          sys_head_nxt = sys_head_inc;
          sys_cnt_nxt  = sys_cnt_r - 1'b1;
        end else if (usr_cnt_r != '0) begin
          fifo_re      = 1'b1;
          fifo_raddr   = {tlpq_pkg::CLS_USER, usr_head_r};
          usr_head_nxt = usr_head_inc;
          usr_cnt_nxt  = usr_cnt_r - 1'b1;
        end else begin
          res_status_nxt = tlpq_pkg::STATUS_IDLE;
          res_slot_nxt   = '0;
          res_first_nxt  = 1'b0;
          res_done_nxt   = 1'b0;
          res_time_nxt   = time_r;
          time_nxt       = time_r + 1'b1;
        end
      end
      tlpq_pkg::ST_FETCH: begin
        run_slot_nxt  = fifo_rd;
        run_valid_nxt = 1'b1;
        task_re       = 1'b1;
        task_raddr    = fifo_rd;
      end
      tlpq_pkg::ST_RUN: begin
        res_status_nxt          = tlpq_pkg::STATUS_RAN;
        res_slot_nxt            = SF_W'(run_slot_r);
        res_first_nxt           = !started_r[run_slot_r];
        res_done_nxt            = (new_rem == '0);
        res_time_nxt            = time_r;
        started_nxt[run_slot_r] = 1'b1;
        task_we                 = 1'b1;
        task_waddr              = run_slot_r;
        task_wdata              = {task_cls, new_rem};
        time_nxt                = time_r + 1'b1;
        if (new_rem == '0) begin
          busy_nxt[run_slot_r] = 1'b0;
          run_valid_nxt        = 1'b0;
        end
      end
      tlpq_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_first_nxt  = res_first_r;
          out_done_nxt   = res_done_r;
          out_time_nxt   = res_time_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlpq_pkg::ST_IDLE;
      sys_head_r  <= '0;
      usr_head_r  <= '0;
      sys_cnt_r   <= '0;
      usr_cnt_r   <= '0;
      run_slot_r  <= '0;
      run_valid_r <= 1'b0;
      time_r      <= '0;
      busy_r      <= '0;
      started_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sys_head_r  <= sys_head_nxt;
      usr_head_r  <= usr_head_nxt;
      sys_cnt_r   <= sys_cnt_nxt;
      usr_cnt_r   <= usr_cnt_nxt;
      run_slot_r  <= run_slot_nxt;
      run_valid_r <= run_valid_nxt;
      time_r      <= time_nxt;
      busy_r      <= busy_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    burst_r      <= burst_nxt;
    sys_r        <= sys_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_first_r  <= res_first_nxt;
    res_done_r   <= res_done_nxt;
    res_time_r   <= res_time_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_first_r  <= out_first_nxt;
    out_done_r   <= out_done_nxt;
    out_time_r   <= out_time_nxt;
  end

  // a running task always holds a busy slot
  `TLPQ_ASSERT(a_run_busy, clk, rst_n, run_valid_r |-> busy_r[run_slot_r], "running slot not busy")
  // the service step only happens with a task selected
  `TLPQ_ASSERT(a_run_sel, clk, rst_n, (state_r == tlpq_pkg::ST_RUN) |-> run_valid_r, "run without task")
  // the preemption check only happens on a running task
  `TLPQ_ASSERT(a_chk_sel, clk, rst_n, (state_r == tlpq_pkg::ST_CHECK) |-> run_valid_r, "check without task")

endmodule
